### src/scrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_pkg
// Shared types and codes of the serial command/response sequencer.
// ----------------------------------------------------------------------------
package scrs_pkg;

    // request kinds on the input stream
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_BYTE  = 2'd2;

    // command codes
    localparam logic [1:0] CMD_GA   = 2'd0;
    localparam logic [1:0] CMD_RE   = 2'd1;
    localparam logic [1:0] CMD_TX   = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // completion status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_TIMEOUT  = 2'd1;
    localparam logic [1:0] STS_CHECKSUM = 2'd2;
    localparam logic [1:0] STS_DEVICE   = 2'd3;

    // result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // configuration register indexes
    localparam int          CFG_IDX_W     = 1;
    localparam logic [0:0]  REG_TIMEOUT   = 1'b0;
    localparam logic [0:0]  REG_MAX_SENDS = 1'b1;

    localparam logic [19:0] TIMEOUT_RESET   = 20'd10000;
    localparam logic [3:0]  MAX_SENDS_RESET = 4'd10;
    localparam logic [19:0] WAIT_MAX        = 20'hFFFFF;
    localparam logic [3:0]  SEND_MAX        = 4'd15;
    localparam logic [9:0]  BLOCK_MAX       = 10'd999;

    // longest frame: "GA," three digits "," two hex digits CR
    localparam int FRAME_MAX = 10;
    localparam int BODY_MAX  = 6;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_X     = 8'h58;

    // work passed from the front to the back
    typedef struct packed {
        logic       is_report;
        logic [1:0] cmd;
        logic [9:0] block;
        logic [1:0] status;
        logic [7:0] err_char;
    } job_t;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] status;
        logic [7:0] err_char;
        logic       busy;
    } result_t;

    // upper-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'h0, v};
        end else begin
            r = (CH_A - 8'd10) + {4'h0, v};
        end
        return r;
    endfunction

endpackage

### src/serial_command_response_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_response_sequencer_core
// Runs one GA, RE or TX command exchange with a serial device.
// ----------------------------------------------------------------------------
// A request is taken whenever the job queue (QUEUE_DEPTH entries) has room, so
// ticks and received bytes stream in back to back. A start request, or a resend
// of RE, queues one frame; the frame unit pops the job, runs the decimal
// conversion B_DIVH, B_DIVR, B_DIVT for GA, builds the frame in B_BUILD and
// sends one byte per cycle (six to ten) while the output is not stalled, taking
// no new job until the frame is sent. A completion report goes straight into
// the free output register, the single result stage; cfg_ready is always high.
module serial_command_response_sequencer_core import scrs_pkg::*; #(
    parameter int LINE_POS_MAX = 63,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [19:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,  // cmd, block_no, rx_byte, zero fill
    input  logic [1:0]           s_tuser,  // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,  // tx_byte, status, error_char, busy_res, zero fill
    output logic                 m_tuser,  // out_kind
    output logic                 m_tlast   // last
);
    logic    queue_full;
    logic    push;
    job_t    push_job;
    logic    head_valid;
    job_t    head_job;
    logic    pop;
    result_t res;

    assign cfg_ready = 1'b1;

    scrs_front #(
        .LINE_POS_MAX(LINE_POS_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_type   (s_tuser),
        .cmd        (s_tdata[1:0]),
        .block_no   (s_tdata[11:2]),
        .rx_byte    (s_tdata[19:12]),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    scrs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    scrs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {5'b0, res.busy, res.err_char, res.status, res.tx_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

### src/scrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_queue
// Short job queue between the request front and the frame back.
// ----------------------------------------------------------------------------
module scrs_queue import scrs_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[head_reg];

    always_comb begin
        head_next  = pop  ? wrap_inc(head_reg) : head_reg;
        tail_next  = push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[tail_reg] <= push_job;
        end
    end

endmodule

### src/scrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_front
// Takes requests, tracks the exchange and reply line, queues frames and reports.
// ----------------------------------------------------------------------------
module scrs_front import scrs_pkg::*; #(
    parameter int LINE_POS_MAX = 63
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [19:0]          cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           req_type,
    input  logic [1:0]           cmd,
    input  logic [9:0]           block_no,
    input  logic [7:0]           rx_byte,
    input  logic                 queue_full,
    output logic                 push,
    output job_t                 push_job
);
    localparam int LP_W = $clog2(LINE_POS_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_REPLY = 3'b010,
        ST_ERR   = 3'b100
    } seq_state_t;

    logic [19:0]     timeout_reg, timeout_next;
    logic [3:0]      max_sends_reg, max_sends_next;
    seq_state_t      state_reg, state_next;
    logic [1:0]      active_reg, active_next;
    logic [9:0]      block_reg, block_next;
    logic [3:0]      sends_reg, sends_next;
    logic [19:0]     wait_reg, wait_next;
    logic [LP_W-1:0] pos_reg, pos_next;
    logic [7:0]      xor_reg, xor_next;
    logic [7:0]      rb0_reg, rb0_next;
    logic [7:0]      rb1_reg, rb1_next;
    logic [7:0]      fourth_reg, fourth_next;

    logic       accept;
    logic       busy;
    logic       sum_ok;
    logic       is_tee;
    logic [19:0] wait_inc;
    logic [9:0] blk_sat;
    logic       send, fin, clr;
    logic [1:0] fin_st;
    logic [7:0] fin_ec;
    logic [1:0] frame_cmd;
    logic [9:0] frame_blk;

    assign req_ready = !queue_full;
    assign accept    = req_valid && req_ready;
    assign busy      = (state_reg != ST_IDLE);
    assign blk_sat   = (block_no > BLOCK_MAX) ? BLOCK_MAX : block_no;
    assign wait_inc  = (wait_reg < WAIT_MAX) ? wait_reg + 20'd1 : wait_reg;
    assign sum_ok    = (pos_reg >= LP_W'(2)) && (rb1_reg == hex_char(xor_reg[7:4]))
                       && (rb0_reg == hex_char(xor_reg[3:0]));
    assign is_tee    = (pos_reg >= LP_W'(1)) && (rx_byte == CH_T)
                       && ((rb0_reg == CH_S) || (rb0_reg == CH_U));

    always_comb begin
        timeout_next   = timeout_reg;
        max_sends_next = max_sends_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMEOUT:   timeout_next   = cfg_data;
                REG_MAX_SENDS: max_sends_next = cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        block_next  = block_reg;
        sends_next  = sends_reg;
        wait_next   = wait_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        rb0_next    = rb0_reg;
        rb1_next    = rb1_reg;
        fourth_next = fourth_reg;
        send        = 1'b0;
        fin         = 1'b0;
        clr         = 1'b0;
        fin_st      = STS_OK;
        fin_ec      = 8'h00;
        frame_cmd   = active_reg;
        frame_blk   = block_reg;

        if (accept) begin
            unique case (req_type)
                REQ_START: begin
                    if (cmd != CMD_NONE) begin
                        active_next = cmd;
                        block_next  = blk_sat;
                        sends_next  = (cmd == CMD_RE) ? 4'd1 : 4'd0;
                        state_next  = ST_REPLY;
                        send        = 1'b1;
                        frame_cmd   = cmd;
                        frame_blk   = blk_sat;
                    end
                end
                REQ_TICK: begin
                    if (busy) begin
                        if (wait_inc >= timeout_reg) begin
                            fin    = 1'b1;
                            fin_st = STS_TIMEOUT;
                        end else begin
                            wait_next = wait_inc;
                        end
                    end
                end
                REQ_BYTE: begin
                    if (busy) begin
                        if (rx_byte == CH_CR) begin
                            fin_ec = fourth_reg;
                            if (state_reg == ST_REPLY) begin
                                if (!sum_ok) begin
                                    fin    = 1'b1;
                                    fin_st = STS_CHECKSUM;
                                end else if (fourth_reg == CH_ZERO) begin
                                    fin    = 1'b1;
                                    fin_st = STS_OK;
                                end else if ((active_reg == CMD_RE)
                                             && (sends_reg < max_sends_reg)) begin
                                    if (sends_reg < SEND_MAX) begin
                                        sends_next = sends_reg + 4'd1;
                                    end
                                    send = 1'b1;
                                end else begin
                                    state_next = ST_ERR;
                                    wait_next  = '0;
                                    clr        = 1'b1;
                                end
                            end else begin
                                fin    = 1'b1;
                                fin_st = ((active_reg == CMD_TX) && !sum_ok) ? STS_CHECKSUM
                                                                             : STS_DEVICE;
                            end
                        end else if (is_tee) begin
                            // status line from the device, dropped
                            clr = 1'b1;
                        end else begin
                            if (pos_reg >= LP_W'(2)) begin
                                xor_next = xor_reg ^ rb1_reg;
                            end
                            rb1_next = rb0_reg;
                            rb0_next = rx_byte;
                            if (pos_reg == LP_W'(3)) begin
                                fourth_next = rx_byte;
                            end
                            if (pos_reg < LP_W'(LINE_POS_MAX)) begin
                                pos_next = pos_reg + LP_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (send) begin
            wait_next = '0;
            clr       = 1'b1;
        end
        if (fin) begin
            state_next = ST_IDLE;
            wait_next  = '0;
            clr        = 1'b1;
        end
        if (clr) begin
            pos_next    = '0;
            xor_next    = '0;
            rb0_next    = '0;
            rb1_next    = '0;
            fourth_next = CH_ZERO;
        end
    end

    always_comb begin
        push               = send || fin;
        push_job.is_report = fin;
        push_job.cmd       = frame_cmd;
        push_job.block     = frame_blk;
        push_job.status    = fin_st;
        push_job.err_char  = fin_ec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            max_sends_reg <= MAX_SENDS_RESET;
            state_reg     <= ST_IDLE;
            active_reg    <= CMD_GA;
            block_reg     <= '0;
            sends_reg     <= '0;
            wait_reg      <= '0;
            pos_reg       <= '0;
            xor_reg       <= '0;
            rb0_reg       <= '0;
            rb1_reg       <= '0;
            fourth_reg    <= CH_ZERO;
        end else begin
            timeout_reg   <= timeout_next;
            max_sends_reg <= max_sends_next;
            state_reg     <= state_next;
            active_reg    <= active_next;
            block_reg     <= block_next;
            sends_reg     <= sends_next;
            wait_reg      <= wait_next;
            pos_reg       <= pos_next;
            xor_reg       <= xor_next;
            rb0_reg       <= rb0_next;
            rb1_reg       <= rb1_next;
            fourth_reg    <= fourth_next;
        end
    end

endmodule

### src/scrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_back
// Turns queued jobs into transmit bytes or completion reports.
// ----------------------------------------------------------------------------
module scrs_back import scrs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    job_valid,
    input  job_t    job,
    output logic    job_pop,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);
    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_DIVH  = 6'b000010,
        B_DIVR  = 6'b000100,
        B_DIVT  = 6'b001000,
        B_BUILD = 6'b010000,
        B_EMIT  = 6'b100000
    } back_state_t;

    back_state_t bstate_reg, bstate_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [9:0]  blk_reg, blk_next;
    logic [3:0]  hund_reg, hund_next;
    logic [6:0]  rem_reg, rem_next;
    logic [3:0]  tens_reg, tens_next;
    logic [7:0]  frame_reg [FRAME_MAX];
    logic [7:0]  frame_next [FRAME_MAX];
    logic [3:0]  len_reg, len_next;
    logic [3:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    result_t     res_reg, res_next;

    logic        out_free;
    logic [15:0] prod41;
    logic [9:0]  hund_x100;
    logic [14:0] prod205;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    logic [7:0]  body [FRAME_MAX];
    logic [3:0]  body_len;
    logic [7:0]  csum;
    logic        emit_last;

    assign out_free  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    // decimal split of the block number, one step per cycle
    assign prod41    = {6'b0, blk_reg} * 16'd41;
    assign hund_x100 = {6'b0, hund_reg} * 10'd100;
    assign prod205   = {8'b0, rem_reg} * 15'd205;
    assign tens_x10  = {3'b0, tens_reg} * 7'd10;
    assign ones      = 4'(rem_reg - tens_x10);

    // command text and its checksum
    always_comb begin
        for (int i = 0; i < FRAME_MAX; i++) begin
            body[i] = 8'h00;
        end
        body_len = 4'd2;
        unique case (cmd_reg)
            CMD_GA: begin
                body[0] = CH_G;
                body[1] = CH_A;
                body[2] = CH_COMMA;
                if (blk_reg >= 10'd100) begin
                    body[3]  = CH_ZERO + {4'h0, hund_reg};
                    body[4]  = CH_ZERO + {4'h0, tens_reg};
                    body[5]  = CH_ZERO + {4'h0, ones};
                    body_len = 4'd6;
                end else if (blk_reg >= 10'd10) begin
                    body[3]  = CH_ZERO + {4'h0, tens_reg};
                    body[4]  = CH_ZERO + {4'h0, ones};
                    body_len = 4'd5;
                end else begin
                    body[3]  = CH_ZERO + {4'h0, ones};
                    body_len = 4'd4;
                end
            end
            CMD_RE: begin
                body[0] = CH_R;
                body[1] = CH_E;
            end
            default: begin
                body[0] = CH_T;
                body[1] = CH_X;
            end
        endcase

        csum = CH_COMMA;
        for (int i = 0; i < BODY_MAX; i++) begin
            if (4'(i) < body_len) begin
                csum = csum ^ body[i];
            end
        end

        for (int i = 0; i < FRAME_MAX; i++) begin
            if (4'(i) < body_len) begin
                frame_next[i] = body[i];
            end else if (4'(i) == body_len) begin
                frame_next[i] = CH_COMMA;
            end else if (4'(i) == body_len + 4'd1) begin
                frame_next[i] = hex_char(csum[7:4]);
            end else if (4'(i) == body_len + 4'd2) begin
                frame_next[i] = hex_char(csum[3:0]);
            end else begin
                frame_next[i] = CH_CR;
            end
        end
    end

    assign emit_last = (idx_reg == len_reg - 4'd1);

    always_comb begin
        bstate_next = bstate_reg;
        cmd_next    = cmd_reg;
        blk_next    = blk_reg;
        hund_next   = hund_reg;
        rem_next    = rem_reg;
        tens_next   = tens_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        job_pop     = 1'b0;
        valid_next  = valid_reg && !res_ready;
        res_next    = res_reg;

        unique case (bstate_reg)
            B_IDLE: begin
                if (job_valid) begin
                    if (job.is_report) begin
                        if (out_free) begin
                            job_pop           = 1'b1;
                            valid_next        = 1'b1;
                            res_next.kind     = KIND_REPORT;
                            res_next.tx_byte  = 8'h00;
                            res_next.last     = 1'b0;
                            res_next.status   = job.status;
                            res_next.err_char = job.err_char;
                            res_next.busy     = 1'b0;
                        end
                    end else begin
                        job_pop     = 1'b1;
                        cmd_next    = job.cmd;
                        blk_next    = job.block;
                        bstate_next = (job.cmd == CMD_GA) ? B_DIVH : B_BUILD;
                    end
                end
            end
            B_DIVH: begin
                hund_next   = prod41[15:12];
                bstate_next = B_DIVR;
            end
            B_DIVR: begin
                rem_next    = 7'(blk_reg - hund_x100);
                bstate_next = B_DIVT;
            end
            B_DIVT: begin
                tens_next   = prod205[14:11];
                bstate_next = B_BUILD;
            end
            B_BUILD: begin
                len_next    = body_len + 4'd4;
                idx_next    = '0;
                bstate_next = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    valid_next        = 1'b1;
                    res_next.kind     = KIND_TX;
                    res_next.tx_byte  = frame_reg[idx_reg];
                    res_next.last     = emit_last;
                    res_next.status   = STS_OK;
                    res_next.err_char = 8'h00;
                    res_next.busy     = 1'b1;
                    idx_next          = idx_reg + 4'd1;
                    if (emit_last) begin
                        bstate_next = B_IDLE;
                    end
                end
            end
            default: bstate_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bstate_reg <= B_IDLE;
            valid_reg  <= 1'b0;
        end else begin
            bstate_reg <= bstate_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        blk_reg  <= blk_next;
        hund_reg <= hund_next;
        rem_reg  <= rem_next;
        tens_reg <= tens_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
        if (bstate_reg == B_BUILD) begin
            for (int i = 0; i < FRAME_MAX; i++) begin
                frame_reg[i] <= frame_next[i];
            end
        end
    end

endmodule

### src/scrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_checker
// Port-level checks of the sequencer result stream.
// ----------------------------------------------------------------------------
module scrs_checker import scrs_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    // no results out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reports never close a frame
    a_report_no_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_REPORT)) |-> !m_tlast)
        else $error("report carries last");

    // busy flag follows the result kind
    a_busy_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18] == (m_tuser == KIND_TX)))
        else $error("busy flag does not match result kind");

    // transmit bytes carry no status
    a_tx_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_TX)) |-> ((m_tdata[9:8] == STS_OK)
                                                && (m_tdata[17:10] == 8'h00)))
        else $error("transmit byte carries status");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind serial_command_response_sequencer_core scrs_checker u_scrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/sv/tb_serial_command_response_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_command_response_sequencer_core
// Self-checking bench for the serial command/response sequencer. Requests
// (ticks, command starts, received bytes) go in through a queued stream
// driver; a cycle-free model of the command exchange predicts every
// transmitted frame byte and completion report, and a monitor compares each
// result leaving the block with the oldest prediction. A short directed run
// is followed by random exchanges with well-formed and broken replies, under
// several timeout and send-limit settings and changing back-pressure.
// ----------------------------------------------------------------------------
module tb_serial_command_response_sequencer_core;
    import scrs_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        SQ_IDLE  = 3'b001,
        SQ_REPLY = 3'b010,
        SQ_ERROR = 3'b100
    } seq_phase_t;

    typedef struct packed {
        logic [1:0] req;
        logic [1:0] cmd;
        logic [9:0] blk;
        logic [7:0] rx;
    } host_req_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [19:0]          cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    serial_command_response_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model of the exchange
    logic [19:0] cfg_tmo;
    logic [3:0]  cfg_sends;
    seq_phase_t  sq_phase;
    logic [1:0]  sq_cmd;
    logic [9:0]  sq_block;
    logic [3:0]  sq_sends;
    logic [19:0] sq_ticks;
    int          ln_pos;
    logic [7:0]  ln_xor;
    logic [7:0]  ln_last;
    logic [7:0]  ln_prev;
    logic [7:0]  ln_fourth;

    result_t     due_outputs[$];
    host_req_t   request_q[$];
    host_req_t   cur_req;
    result_t     got;
    result_t     want;
    logic        req_taken;
    int          send_idle;
    int          recv_idle;
    int          errors;
    int          items_made;

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10) ? (CH_ZERO + {4'h0, n}) : (CH_A - 8'd10 + {4'h0, n});
    endfunction

    task automatic clear_line();
        ln_pos    = 0;
        ln_xor    = 8'h00;
        ln_last   = 8'h00;
        ln_prev   = 8'h00;
        ln_fourth = CH_ZERO;
    endtask

    task automatic add_result(input logic kind, input logic [7:0] b, input logic lst,
                              input logic [1:0] st, input logic [7:0] ec, input logic bsy);
        result_t r;
        r.kind     = kind;
        r.tx_byte  = b;
        r.last     = lst;
        r.status   = st;
        r.err_char = ec;
        r.busy     = bsy;
        due_outputs.push_back(r);
    endtask

    task automatic emit_frame();
        logic [7:0] fr[$];
        logic [7:0] x;
        x = 8'h00;
        if (sq_cmd == CMD_GA) begin
            fr.push_back(CH_G);
            fr.push_back(CH_A);
            fr.push_back(CH_COMMA);
            if (sq_block >= 10'd100) fr.push_back(CH_ZERO + 8'(sq_block / 10'd100));
            if (sq_block >= 10'd10) fr.push_back(CH_ZERO + 8'((sq_block / 10'd10) % 10'd10));
            fr.push_back(CH_ZERO + 8'(sq_block % 10'd10));
        end else if (sq_cmd == CMD_RE) begin
            fr.push_back(CH_R);
            fr.push_back(CH_E);
        end else begin
            fr.push_back(CH_T);
            fr.push_back(CH_X);
        end
        fr.push_back(CH_COMMA);
        foreach (fr[i]) x ^= fr[i];
        fr.push_back(hex_ascii(x[7:4]));
        fr.push_back(hex_ascii(x[3:0]));
        foreach (fr[i]) add_result(KIND_TX, fr[i], 1'b0, STS_OK, 8'h00, 1'b1);
        add_result(KIND_TX, CH_CR, 1'b1, STS_OK, 8'h00, 1'b1);
        clear_line();
        sq_ticks = 20'd0;
    endtask

    task automatic close_cmd(input logic [1:0] st, input logic [7:0] ec);
        sq_phase = SQ_IDLE;
        sq_ticks = 20'd0;
        clear_line();
        add_result(KIND_REPORT, 8'h00, 1'b0, st, ec, 1'b0);
    endtask

    task automatic line_end();
        logic       sum_ok;
        logic [7:0] ec;
        sum_ok = ln_pos >= 2 && ln_prev == hex_ascii(ln_xor[7:4]) &&
                 ln_last == hex_ascii(ln_xor[3:0]);
        ec = ln_fourth;
        if (sq_phase == SQ_REPLY) begin
            if (!sum_ok) begin
                close_cmd(STS_CHECKSUM, ec);
            end else if (ec == CH_ZERO) begin
                close_cmd(STS_OK, ec);
            end else if (sq_cmd == CMD_RE && sq_sends < cfg_sends) begin
                if (sq_sends < SEND_MAX) sq_sends = sq_sends + 4'd1;
                emit_frame();
            end else begin
                sq_phase = SQ_ERROR;
                sq_ticks = 20'd0;
                clear_line();
            end
        end else if (sq_cmd == CMD_TX && !sum_ok) begin
            close_cmd(STS_CHECKSUM, ec);
        end else begin
            close_cmd(STS_DEVICE, ec);
        end
    endtask

    task automatic sequencer_step(input host_req_t r);
        if (r.req == REQ_START) begin
            if (r.cmd != CMD_NONE) begin
                sq_cmd   = r.cmd;
                sq_block = (r.blk > BLOCK_MAX) ? BLOCK_MAX : r.blk;
                sq_sends = (r.cmd == CMD_RE) ? 4'd1 : 4'd0;
                sq_phase = SQ_REPLY;
                emit_frame();
            end
        end else if (sq_phase == SQ_IDLE) begin
            // ignored while idle
        end else if (r.req == REQ_TICK) begin
            if (sq_ticks < WAIT_MAX) sq_ticks = sq_ticks + 20'd1;
            if (sq_ticks >= cfg_tmo) close_cmd(STS_TIMEOUT, 8'h00);
        end else if (r.req == REQ_BYTE) begin
            if (r.rx == CH_CR) begin
                line_end();
            end else if (ln_pos >= 1 && r.rx == CH_T && (ln_last == CH_S || ln_last == CH_U)) begin
                clear_line();
            end else begin
                if (ln_pos >= 2) ln_xor ^= ln_prev;
                ln_prev = ln_last;
                ln_last = r.rx;
                if (ln_pos == 3) ln_fourth = r.rx;
                if (ln_pos < 63) ln_pos++;
            end
        end
    endtask

    // input side: requests are taken at the rising edge, next one set up at the falling edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                req_taken = 1'b1;
                sequencer_step(cur_req);
            end
            if (m_tvalid && m_tready) begin
                got.kind     = m_tuser;
                got.tx_byte  = m_tdata[7:0];
                got.last     = m_tlast;
                got.status   = m_tdata[9:8];
                got.err_char = m_tdata[17:10];
                got.busy     = m_tdata[18];
                if (due_outputs.size() == 0) begin
                    $display("%0t: result with nothing expected: kind=%0d byte=%02h",
                             $time, got.kind, got.tx_byte);
                    errors++;
                end else begin
                    want = due_outputs.pop_front();
                    if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                        got.last !== want.last || got.status !== want.status ||
                        got.err_char !== want.err_char || got.busy !== want.busy) begin
                        // kind, byte, last, status, error char, busy from the top bit down
                        $display("%0t: mismatch expected %07h actual %07h",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || req_taken) begin
                if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    cur_req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.req;
                    s_tdata  <= {4'h0, cur_req.rx, cur_req.blk, cur_req.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            req_taken = 1'b0;
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic push(input logic [1:0] rq, input logic [1:0] c, input logic [9:0] b,
                        input logic [7:0] d);
        host_req_t r;
        r.req = rq;
        r.cmd = c;
        r.blk = b;
        r.rx  = d;
        request_q.push_back(r);
        items_made++;
    endtask

    task automatic push_byte(input logic [7:0] d);
        push(REQ_BYTE, 2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)), d);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push(REQ_TICK, 2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                        8'($urandom_range(0, 255)));
    endtask

    task automatic push_noise(input int n);
        repeat (n) push(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                        10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [9:0] rand_block();
        unique case ($urandom_range(0, 9))
            0, 1, 2: return 10'($urandom_range(0, 9));
            3, 4, 5: return 10'($urandom_range(10, 99));
            6, 7, 8: return 10'($urandom_range(100, 999));
            default: return 10'($urandom_range(1000, 1023));
        endcase
    endfunction

    function automatic logic [7:0] rand_err();
        if ($urandom_range(0, 2) != 0) return CH_ZERO + 8'($urandom_range(1, 9));
        return CH_A + 8'($urandom_range(0, 9));
    endfunction

    // reply line: body, checksum digits, CR; the device error digit sits fourth
    task automatic push_reply(input logic [7:0] ec, input logic good, input int blen);
        logic [7:0] body[$];
        logic [7:0] x;
        logic [7:0] c;
        logic [7:0] hi;
        logic [7:0] lo;
        x = 8'h00;
        for (int i = 0; i < blen; i++) begin
            c = (i == 3) ? ec : 8'($urandom_range(33, 126));
            if (i != 3 && i > 0 && c == CH_T && (body[i-1] == CH_S || body[i-1] == CH_U))
                c = CH_X;
            body.push_back(c);
            x ^= c;
        end
        hi = hex_ascii(x[7:4]);
        lo = hex_ascii(x[3:0]);
        if (!good) begin
            // low digit with bit 5 flipped (lower case for A-F) or a wrong high digit
            if ($urandom_range(0, 1) != 0) lo ^= 8'h20;
            else hi = hex_ascii(x[7:4] + 4'd1);
        end
        foreach (body[i]) push_byte(body[i]);
        push_byte(hi);
        push_byte(lo);
        push_byte(CH_CR);
    endtask

    task automatic push_short();
        if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(33, 126)));
        push_byte(CH_CR);
    endtask

    // status line fragment that the block throws away
    task automatic push_discard();
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(33, 126)));
        push_byte(($urandom_range(0, 1) != 0) ? CH_S : CH_U);
        push_byte(CH_T);
    endtask

    task automatic push_exchange();
        logic [1:0] c;
        logic [7:0] ec;
        int         nrep;
        c = 2'($urandom_range(0, 2));
        push(REQ_START, c, rand_block(), 8'($urandom_range(0, 255)));
        nrep = (c == CMD_RE) ? $urandom_range(1, 6) : $urandom_range(1, 2);
        for (int i = 0; i < nrep; i++) begin
            if ($urandom_range(0, 4) == 0) push_ticks($urandom_range(1, 4));
            if ($urandom_range(0, 4) == 0) push_discard();
            case ($urandom_range(0, 9))
                0: push_short();
                1: push_reply(rand_err(), $urandom_range(0, 3) != 0, $urandom_range(0, 3));
                default: begin
                    ec = (i == nrep - 1 && $urandom_range(0, 2) != 0) ? CH_ZERO : rand_err();
                    push_reply(ec, $urandom_range(0, 7) != 0, $urandom_range(4, 9));
                end
            endcase
            // occasionally leave the exchange open so the next start drops it
            if ($urandom_range(0, 11) == 0) break;
        end
        if ($urandom_range(0, 5) == 0) push_ticks($urandom_range(1, 8));
    endtask

    task automatic run_random(input int target);
        items_made = 0;
        while (items_made < target) begin
            if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 4));
            else push_exchange();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_TIMEOUT) cfg_tmo = val;
        else cfg_sends = val[3:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (request_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = 20'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 24'd0;
        s_tuser   = REQ_TICK;
        m_tready  = 1'b0;
        req_taken = 1'b0;
        errors    = 0;
        cfg_tmo   = TIMEOUT_RESET;
        cfg_sends = MAX_SENDS_RESET;
        sq_phase  = SQ_IDLE;
        sq_cmd    = CMD_GA;
        sq_block  = 10'd0;
        sq_sends  = 4'd0;
        sq_ticks  = 20'd0;
        clear_line();
        send_idle = 36;
        recv_idle = 74;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: idle traffic, ignored codes, saturation, restart, short reply, resend
        push(REQ_BYTE, CMD_NONE, 10'h3FF, 8'hFF);
        push(REQ_TICK, CMD_NONE, 10'h000, 8'h00);
        push(REQ_UNUSED, CMD_RE, 10'h155, 8'hAA);
        push(REQ_START, CMD_NONE, 10'd5, 8'h00);
        push(REQ_START, CMD_GA, 10'h3FF, 8'h00);
        push(REQ_START, CMD_TX, 10'd0, 8'h00);
        push_byte(CH_CR);
        push(REQ_START, CMD_RE, 10'd5, 8'h00);
        push_reply(CH_ZERO + 8'd7, 1'b1, 4);
        push_reply(CH_ZERO, 1'b1, 4);
        push(REQ_START, CMD_GA, 10'd99, 8'h00);
        push_byte(CH_X);
        push_byte(CH_CR);
        drain();

        write_reg(REG_TIMEOUT, 20'd1);
        write_reg(REG_MAX_SENDS, 20'd1);
        run_random(120);
        drain();

        send_idle = 74;
        recv_idle = 36;
        write_reg(REG_TIMEOUT, 20'hFFFFF);
        write_reg(REG_MAX_SENDS, 20'd15);
        run_random(120);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_TIMEOUT, 20'd6);
        write_reg(REG_MAX_SENDS, 20'd3);
        run_random(125);
        drain();

        if (errors == 0) begin
            $display("serial_command_response_sequencer_core test passed");
        end else begin
            $display("serial_command_response_sequencer_core test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("serial_command_response_sequencer_core test failed");
        $finish;
    end

endmodule
